// ===== rtl/core/lu8_pkg.sv =====
`default_nettype none

package lu8_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned CpW      = 21;
	localparam int unsigned WinDepth = 4;
	localparam int unsigned PendDepth = 3;

	localparam logic [7:0] AsciiLimit = 8'h80;
	localparam logic [7:0] Lead2Mask  = 8'hE0;
	localparam logic [7:0] Lead2Code  = 8'hC0;
	localparam logic [7:0] Lead3Mask  = 8'hF0;
	localparam logic [7:0] Lead3Code  = 8'hE0;
	localparam logic [7:0] Lead4Mask  = 8'hF8;
	localparam logic [7:0] Lead4Code  = 8'hF0;
	localparam logic [7:0] Pay2Mask   = 8'h1F;
	localparam logic [7:0] Pay3Mask   = 8'h0F;
	localparam logic [7:0] Pay4Mask   = 8'h07;
	localparam logic [7:0] ContMask   = 8'h3F;

	// bytes of one finished run, lead first, with its length
	typedef struct packed {
		logic [WinDepth-1:0][ByteW-1:0] bytes;
		logic [2:0]                     n;
		logic                           last;
	} lu8_win_t;

	// code points that one run produces
	typedef struct packed {
		logic [WinDepth-1:0][CpW-1:0] cp;
		logic [2:0]                   cnt;
		logic                         last;
	} lu8_run_t;

	// sequence length opened by a byte, 1 for a lone byte
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if (b < AsciiLimit) len = 3'd1;
		else if ((b & Lead2Mask) == Lead2Code) len = 3'd2;
		else if ((b & Lead3Mask) == Lead3Code) len = 3'd3;
		else if ((b & Lead4Mask) == Lead4Code) len = 3'd4;
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lu8_byte_if.sv =====
`default_nettype none

interface lu8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lu8_cp_if.sv =====
`default_nettype none

interface lu8_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        run_last;
	logic        text_last;

	modport source (output valid, output code_point, output run_last, output text_last,
		input ready);
	modport sink (input valid, input code_point, input run_last, input text_last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lu8_run_decode.sv =====
`default_nettype none

module lu8_run_decode (
	input  var lu8_pkg::lu8_win_t win,
	output var lu8_pkg::lu8_run_t run
);

	function automatic logic [7:0] byte_at(input lu8_pkg::lu8_win_t w, input logic [3:0] idx);
		logic [7:0] b;
		b = '0;
		if (idx < 4'(lu8_pkg::WinDepth)) b = w.bytes[idx[1:0]];
		return b;
	endfunction

	always_comb begin
		logic [3:0]  pos;
		logic [7:0]  lead;
		logic [2:0]  len;
		logic [20:0] v;
		logic [7:0]  cont;
		pos  = '0;
		v    = '0;
		cont = '0;
		run = '0;
		run.last = win.last;
		// at most four results: walk the run once per slot
		for (int j = 0; j < int'(lu8_pkg::WinDepth); j++) begin
			lead = byte_at(win, pos);
			len  = lu8_pkg::seq_len(lead);
			if (pos < {1'b0, win.n}) begin
				if (len > 3'd1 && (pos + {1'b0, len}) <= {1'b0, win.n}) begin
					case (len)
						3'd2: v = 21'(lead & lu8_pkg::Pay2Mask);
						3'd3: v = 21'(lead & lu8_pkg::Pay3Mask);
						default: v = 21'(lead & lu8_pkg::Pay4Mask);
					endcase
					for (int i = 1; i < int'(lu8_pkg::WinDepth); i++) begin
						cont = byte_at(win, pos + 4'(i));
						if (3'(i) < len) v = {v[14:0], cont[5:0] & lu8_pkg::ContMask[5:0]};
					end
					pos = pos + {1'b0, len};
				end else begin
					v   = 21'(lead);
					pos = pos + 4'd1;
				end
				run.cp[j] = v;
				run.cnt   = 3'(j + 1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lenient_utf8_decoder_unit.sv =====
// Lenient UTF-8 decoder: takes one text byte per cycle on bytes when not stalled and gives
// code points on codes. A complete sequence is registered in the window stage and then in
// the result buffer, which gives its code point. Continuation bytes are merged without
// checking, and stray or invalid bytes come out as their own value. When the final byte
// (end_of_text) lands inside an unfinished sequence, the buffered bytes are replayed and up
// to four results come out, one per cycle from the result buffer while codes is ready; that
// buffer limits the rate: while it is busy, a finished run waits in the window stage and
// holds back new bytes. run_last marks the last result of an input byte, text_last the last of the text.
`default_nettype none

module lenient_utf8_decoder_unit (
	input  wire          clk,
	input  wire          arst_n,
	lu8_byte_if.sink     bytes,
	lu8_cp_if.source     codes
);

	logic [lu8_pkg::PendDepth-1:0][7:0] pend_q;
	logic [1:0]                         pend_cnt_q;

	lu8_pkg::lu8_win_t win_in;
	lu8_pkg::lu8_win_t win_s1;
	logic              valid_s1;
	logic              complete;

	lu8_pkg::lu8_run_t run;
	logic [lu8_pkg::WinDepth-1:0][20:0] buf_cp_q;
	logic [2:0] buf_cnt_q;
	logic [1:0] buf_idx_q;
	logic       buf_end_q;
	logic       buf_valid_q;
	logic       buf_last;
	logic       buf_free;
	logic       out_fire;
	logic       in_fire;
	logic       s1_adv;

	// window = pending bytes followed by the new byte
	always_comb begin
		win_in = '0;
		for (int i = 0; i < int'(lu8_pkg::PendDepth); i++) begin
			if (i < int'(pend_cnt_q)) win_in.bytes[i] = pend_q[i];
		end
		win_in.bytes[pend_cnt_q] = bytes.text_byte;
		win_in.n    = {1'b0, pend_cnt_q} + 3'd1;
		win_in.last = bytes.end_of_text;
	end

	assign complete = bytes.end_of_text || (win_in.n >= lu8_pkg::seq_len(win_in.bytes[0]));

	assign buf_last = (buf_idx_q == 2'(buf_cnt_q - 3'd1));
	assign out_fire = codes.valid && codes.ready;
	assign buf_free = !buf_valid_q || (out_fire && buf_last);
	assign s1_adv   = valid_s1 && buf_free;
	assign bytes.ready = !valid_s1 || buf_free;
	assign in_fire  = bytes.valid && bytes.ready;

	lu8_run_decode u_dec (
		.win (win_s1),
		.run (run)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q  <= '0;
			valid_s1    <= 1'b0;
			buf_valid_q <= 1'b0;
			buf_idx_q   <= '0;
		end else begin
			if (in_fire) begin
				if (complete) begin
					pend_cnt_q <= '0;
				end else begin
					pend_q[pend_cnt_q] <= bytes.text_byte;
					pend_cnt_q         <= pend_cnt_q + 2'd1;
				end
				valid_s1 <= complete;
				win_s1   <= win_in;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end

			if (s1_adv) begin
				buf_valid_q <= 1'b1;
				buf_cp_q    <= run.cp;
				buf_cnt_q   <= run.cnt;
				buf_end_q   <= run.last;
				buf_idx_q   <= '0;
			end else if (out_fire) begin
				// advance within the run, drop the buffer after its last word
				if (buf_last) buf_valid_q <= 1'b0;
				else buf_idx_q <= buf_idx_q + 2'd1;
			end
		end
	end

	assign codes.valid      = buf_valid_q;
	assign codes.code_point = buf_cp_q[buf_idx_q];
	assign codes.run_last   = buf_last;
	assign codes.text_last  = buf_last && buf_end_q;

endmodule

`default_nettype wire

// ===== rtl/core/lu8_checker.sv =====
`default_nettype none

module lu8_checker (
	input wire clk,
	input wire arst_n,
	input wire out_valid,
	input wire out_ready,
	input wire run_last,
	input wire text_last
);

	default disable iff (!arst_n);

	a_valid_hold: assert property (@(posedge clk) out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_text_implies_run: assert property (@(posedge clk) out_valid && text_last |-> run_last)
		else $error("text_last without run_last");

	a_run_continues: assert property (@(posedge clk)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("run broken before its last word");

endmodule

bind lenient_utf8_decoder_unit lu8_checker u_lu8_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (codes.valid),
	.out_ready (codes.ready),
	.run_last  (codes.run_last),
	.text_last (codes.text_last)
);

`default_nettype wire
